[hdl/pfa_pkg.sv]
// Shared constants, codes and types of the page frame allocator.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps
package pfa_pkg;
	localparam int NUM_FRAMES = 32;
	localparam int OWNER_BITS = 8;
	localparam int PAGE_BITS  = 20;

	localparam int FRAME_W = $clog2(NUM_FRAMES);
	localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
	localparam int CFG_W   = 6;
	localparam int SIZE_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int DATA_W  = OWNER_BITS + PAGE_BITS;

	localparam logic [2:0] CMD_ALLOC  = 3'd0;
	localparam logic [2:0] CMD_FREE   = 3'd1;
	localparam logic [2:0] CMD_PIN    = 3'd2;
	localparam logic [2:0] CMD_UNPIN  = 3'd3;
	localparam logic [2:0] CMD_ACCESS = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ALLPIN = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	localparam logic [1:0] CFG_FRAMES = 2'd0;
	localparam logic [1:0] CFG_POLICY = 2'd1;

	localparam logic POLICY_FIFO = 1'b0;

	localparam logic [CFG_W-1:0] FIU_RESET = 6'd32;
	localparam int RESET_SIZE = (NUM_FRAMES < 32) ? NUM_FRAMES : 32;
	localparam logic [FRAME_W-1:0] HAND_RESET = FRAME_W'(RESET_SIZE - 1);

	typedef struct packed {
		logic free;
		logic pinned;
		logic used;
		logic dirty;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{free: 1'b1, pinned: 1'b0, used: 1'b0, dirty: 1'b0};
endpackage

[hdl/pfa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hdl/page_frame_allocator_clock.sv]
// Page frame allocator with FIFO or enhanced second-chance clock replacement.
// Depends on pfa_pkg and pfa_ram.
`timescale 1ns / 1ps
// Steps: a census scan over the n managed frames (n = managed frames), an apply step,
// a fetch step for allocate, then the result register is loaded once the last result is taken.
// A replacement scan visits frames with a flag RAM read, then an evaluate and
// write-back step, up to 4n visits.
// One item at a time; the next item is taken once the result is registered.
// Reset (arst_n low): every frame free via per-entry valid bits, hand at
// size minus one, registers 32 and 1; owner and page stores are unset.
module page_frame_allocator_clock (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        command,
	input  logic [pfa_pkg::FRAME_W-1:0]       frame,
	input  logic [pfa_pkg::OWNER_BITS-1:0]    owner_id,
	input  logic [pfa_pkg::PAGE_BITS-1:0]     page_number,
	input  logic                              is_write,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pfa_pkg::FRAME_W-1:0]       granted_frame,
	output logic                              evicted,
	output logic [pfa_pkg::OWNER_BITS-1:0]    victim_owner,
	output logic [pfa_pkg::PAGE_BITS-1:0]     victim_page,
	output logic                              victim_dirty,
	output logic [1:0]                        status,
	output logic [pfa_pkg::CNT_W-1:0]         free_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [pfa_pkg::CFG_W-1:0]         cfg_data
);
	localparam int FW = pfa_pkg::FRAME_W;
	localparam int SW = pfa_pkg::SIZE_W;
	localparam int CW = pfa_pkg::CNT_W;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_VRD, S_VEV, S_APPLY, S_FETCH, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [pfa_pkg::CFG_W-1:0] fiu_q;
	logic                      policy_q;
	logic [SW-1:0]             eff_n;

	// latched item
	logic [2:0]                     cmd_q;
	logic [FW-1:0]                  fr_q;
	logic [pfa_pkg::OWNER_BITS-1:0] own_q;
	logic [pfa_pkg::PAGE_BITS-1:0]  pg_q;
	logic                           wr_q;
	logic [SW-1:0]                  n_q;

	// census scan
	logic [SW-1:0] rd_idx_q;
	logic          chk_v_s1;
	logic [FW-1:0] chk_idx_s1;
	logic          found_free_q;
	logic          any_unpin_q;
	logic [CW-1:0] cnt_q;
	pfa_pkg::flags_t frf_q;

	// replacement
	logic [FW-1:0] hand_q;
	logic [FW-1:0] vidx_q;
	logic [1:0]    pass_q;
	logic [SW-1:0] k_q;

	// results
	logic [FW-1:0]                  tgt_q;
	logic                           ev_q;
	logic                           vdirty_q;
	logic [pfa_pkg::OWNER_BITS-1:0] vown_q;
	logic [pfa_pkg::PAGE_BITS-1:0]  vpg_q;
	logic [1:0]                     st_q;

	// flag store: RAM plus per-entry valid bits
	logic [pfa_pkg::NUM_FRAMES-1:0] valid_q;
	logic                           vld_rd_s1;
	logic                           fl_we;
	logic [FW-1:0]                  fl_waddr;
	pfa_pkg::flags_t                fl_wdata;
	logic [FW-1:0]                  fl_raddr;
	pfa_pkg::flags_t                fl_dout;
	pfa_pkg::flags_t                fl;

	// owner and page store
	logic                        d_we;
	logic [pfa_pkg::DATA_W-1:0]  d_dout;

	function automatic logic [FW-1:0] nxt(input logic [FW-1:0] i, input logic [SW-1:0] n);
		logic [SW-1:0] p;
		p = SW'(i) + SW'(1);
		return (p >= n) ? '0 : p[FW-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);

	// clamp the managed size to 1..NUM_FRAMES
	always_comb begin
		if (fiu_q == '0) begin
			eff_n = SW'(1);
		end else if (SW'(fiu_q) > SW'(pfa_pkg::NUM_FRAMES)) begin
			eff_n = SW'(pfa_pkg::NUM_FRAMES);
		end else begin
			eff_n = SW'(fiu_q);
		end
	end

	// entries never written read as the reset flags
	assign fl = vld_rd_s1 ? fl_dout : pfa_pkg::FLAGS_RESET;

	always_comb begin
		fl_raddr = vidx_q;
		if (state_q == S_SCAN) begin
			fl_raddr = rd_idx_q[FW-1:0];
		end
	end

	// flag write port: use-bit clearing during the clock pass, or the apply step
	always_comb begin
		fl_we    = 1'b0;
		fl_waddr = vidx_q;
		fl_wdata = fl;
		if (state_q == S_VEV) begin
			if (policy_q != pfa_pkg::POLICY_FIFO && !fl.pinned && pass_q == 2'd1
					&& !(!fl.used && fl.dirty)) begin
				fl_we         = 1'b1;
				fl_wdata.used = 1'b0;
			end
		end else if (state_q == S_APPLY && st_q == pfa_pkg::ST_OK) begin
			if (cmd_q == pfa_pkg::CMD_ALLOC) begin
				fl_we    = 1'b1;
				fl_waddr = tgt_q;
				fl_wdata = '{free: 1'b0, pinned: 1'b1, used: 1'b0, dirty: 1'b0};
			end else begin
				fl_waddr = fr_q;
				fl_wdata = frf_q;
				unique case (cmd_q)
					pfa_pkg::CMD_FREE: begin
						fl_we    = 1'b1;
						fl_wdata = pfa_pkg::FLAGS_RESET;
					end
					pfa_pkg::CMD_PIN: begin
						fl_we           = 1'b1;
						fl_wdata.pinned = 1'b1;
					end
					pfa_pkg::CMD_UNPIN: begin
						fl_we           = 1'b1;
						fl_wdata.pinned = 1'b0;
					end
					pfa_pkg::CMD_ACCESS: begin
						fl_we         = 1'b1;
						fl_wdata.used = 1'b1;
						fl_wdata.dirty = frf_q.dirty | wr_q;
					end
					default: fl_we = 1'b0;
				endcase
			end
		end
	end

	assign d_we = (state_q == S_FETCH);

	pfa_ram #(
		.WIDTH ($bits(pfa_pkg::flags_t)),
		.DEPTH (pfa_pkg::NUM_FRAMES)
	) u_flags (
		.clk   (clk),
		.we    (fl_we),
		.waddr (fl_waddr),
		.wdata (fl_wdata),
		.raddr (fl_raddr),
		.rdata (fl_dout)
	);

	pfa_ram #(
		.WIDTH (pfa_pkg::DATA_W),
		.DEPTH (pfa_pkg::NUM_FRAMES)
	) u_data (
		.clk   (clk),
		.we    (d_we),
		.waddr (tgt_q),
		.wdata ({own_q, pg_q}),
		.raddr (tgt_q),
		.rdata (d_dout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fl_we) begin
			valid_q[fl_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		vld_rd_s1 <= valid_q[fl_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fiu_q     <= pfa_pkg::FIU_RESET;
			policy_q  <= 1'b1;
			hand_q    <= pfa_pkg::HAND_RESET;
			out_valid <= 1'b0;
			chk_v_s1  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pfa_pkg::CFG_FRAMES) begin
					fiu_q <= cfg_data;
				end else if (cfg_index == pfa_pkg::CFG_POLICY) begin
					policy_q <= cfg_data[0];
				end
			end
			// drop the result once taken; the result step reloads it itself
			if (out_valid && !out_stall && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q        <= command;
						fr_q         <= frame;
						own_q        <= owner_id;
						pg_q         <= page_number;
						wr_q         <= is_write;
						n_q          <= eff_n;
						rd_idx_q     <= '0;
						found_free_q <= 1'b0;
						any_unpin_q  <= 1'b0;
						cnt_q        <= '0;
						frf_q        <= pfa_pkg::FLAGS_RESET;
						ev_q         <= 1'b0;
						vdirty_q     <= 1'b0;
						vown_q       <= '0;
						vpg_q        <= '0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue one read a cycle, count on the beat after
					chk_v_s1 <= (rd_idx_q < n_q);
					if (rd_idx_q < n_q) begin
						chk_idx_s1 <= rd_idx_q[FW-1:0];
						rd_idx_q   <= rd_idx_q + SW'(1);
					end
					if (chk_v_s1) begin
						if (fl.free) begin
							cnt_q <= cnt_q + CW'(1);
							if (!found_free_q) begin
								found_free_q <= 1'b1;
								tgt_q        <= chk_idx_s1;
							end
						end
						if (!fl.pinned) begin
							any_unpin_q <= 1'b1;
						end
						if (chk_idx_s1 == fr_q) begin
							frf_q <= fl;
						end
					end else if (rd_idx_q >= n_q) begin
						// census complete: classify the item
						if (cmd_q == pfa_pkg::CMD_ALLOC && !found_free_q && any_unpin_q) begin
							vidx_q  <= nxt(hand_q, n_q);
							pass_q  <= 2'd0;
							k_q     <= '0;
							st_q    <= pfa_pkg::ST_OK;
							state_q <= S_VRD;
						end else begin
							state_q <= S_APPLY;
							if (cmd_q == pfa_pkg::CMD_ALLOC && !found_free_q) begin
								st_q <= pfa_pkg::ST_ALLPIN;
							end else if (cmd_q != pfa_pkg::CMD_ALLOC
									&& cmd_q <= pfa_pkg::CMD_ACCESS && SW'(fr_q) >= n_q) begin
								st_q <= pfa_pkg::ST_RANGE;
							end else begin
								st_q <= pfa_pkg::ST_OK;
							end
						end
					end
				end
				S_VRD: begin
					state_q <= S_VEV;
				end
				S_VEV: begin
					if (!fl.pinned && (policy_q == pfa_pkg::POLICY_FIFO
							|| (!fl.used && fl.dirty == pass_q[0]))) begin
						tgt_q    <= vidx_q;
						hand_q   <= vidx_q;
						ev_q     <= 1'b1;
						vdirty_q <= fl.dirty;
						state_q  <= S_APPLY;
					end else begin
						// advance the scan index, wrap into the next pass
						vidx_q <= nxt(vidx_q, n_q);
						if (k_q == n_q - SW'(1)) begin
							k_q    <= '0;
							pass_q <= pass_q + 2'd1;
						end else begin
							k_q <= k_q + SW'(1);
						end
						state_q <= S_VRD;
					end
				end
				S_APPLY: begin
					if (st_q == pfa_pkg::ST_OK && cmd_q == pfa_pkg::CMD_ALLOC) begin
						if (!ev_q) begin
							cnt_q <= cnt_q - CW'(1);
						end
						state_q <= S_FETCH;
					end else begin
						if (st_q == pfa_pkg::ST_OK && cmd_q == pfa_pkg::CMD_FREE
								&& !frf_q.free) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_FETCH: begin
					// old owner and page arrive as the new ones are written
					if (ev_q) begin
						{vown_q, vpg_q} <= d_dout;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid     <= 1'b1;
						granted_frame <= (cmd_q == pfa_pkg::CMD_ALLOC && st_q == pfa_pkg::ST_OK)
							? tgt_q : '0;
						evicted       <= ev_q;
						victim_owner  <= vown_q;
						victim_page   <= vpg_q;
						victim_dirty  <= vdirty_q;
						status        <= st_q;
						free_count    <= cnt_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[tb/sv/testbench.sv]
// Self-checking testbench of page_frame_allocator_clock: directed table, then random phases.
// Depends on pfa_pkg and the allocator RTL; a built-in predictor or typed-in rows supply expected beats.
`timescale 1ns / 1ps
module testbench;
	import pfa_pkg::*;

	// Commands 5 to 7 are not decoded by the block and must leave state alone.
	localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
	localparam logic       POLICY_CLOCK   = 1'b1;
	localparam int         CYCLE_LIMIT    = 1000000;
	localparam int         HOLDOFF_CYCLES = 400;
	localparam int         SETTLE_CYCLES  = 300;

	typedef struct packed {
		logic [FRAME_W-1:0]    granted;
		logic                  evicted;
		logic [OWNER_BITS-1:0] owner;
		logic [PAGE_BITS-1:0]  page;
		logic                  dirty;
		logic [1:0]            status;
		logic [CNT_W-1:0]      free_cnt;
	} frame_result_t;

	typedef struct {
		bit                    is_cfg;
		logic [1:0]            cfg_idx;
		logic [CFG_W-1:0]      cfg_val;
		logic [2:0]            cmd;
		logic [FRAME_W-1:0]    frm;
		logic [OWNER_BITS-1:0] own;
		logic [PAGE_BITS-1:0]  pg;
		logic                  wr;
		bit                    typed;
		frame_result_t         want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] command = '0;
	logic [FRAME_W-1:0] frame = '0;
	logic [OWNER_BITS-1:0] owner_id = '0;
	logic [PAGE_BITS-1:0] page_number = '0;
	logic is_write = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FRAME_W-1:0] granted_frame;
	logic evicted;
	logic [OWNER_BITS-1:0] victim_owner;
	logic [PAGE_BITS-1:0] victim_page;
	logic victim_dirty;
	logic [1:0] status;
	logic [CNT_W-1:0] free_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// Shadow copy of the frame table.
	bit                    tbl_free   [NUM_FRAMES];
	bit                    tbl_pinned [NUM_FRAMES];
	bit                    tbl_used   [NUM_FRAMES];
	bit                    tbl_dirty  [NUM_FRAMES];
	logic [OWNER_BITS-1:0] tbl_owner  [NUM_FRAMES];
	logic [PAGE_BITS-1:0]  tbl_page   [NUM_FRAMES];
	int                    clock_hand;
	int                    managed;
	logic                  policy;

	frame_result_t pending_q[$];
	stim_row_t     dir_rows[$];
	int            errors = 0;
	int            cycles = 0;
	bit            quiet = 1'b0;
	bit            hold_req = 1'b0;

	page_frame_allocator_clock u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .frame(frame), .owner_id(owner_id),
		.page_number(page_number), .is_write(is_write),
		.out_valid(out_valid), .out_stall(out_stall),
		.granted_frame(granted_frame), .evicted(evicted),
		.victim_owner(victim_owner), .victim_page(victim_page),
		.victim_dirty(victim_dirty), .status(status), .free_count(free_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Clamp the raw register to 1..NUM_FRAMES, as the block does.
	function automatic void set_managed(input logic [CFG_W-1:0] raw);
		managed = (raw < 1) ? 1 : ((raw > NUM_FRAMES) ? NUM_FRAMES : int'(raw));
	endfunction

	function automatic int step_frame(input int i);
		return (i + 1 >= managed) ? 0 : i + 1;
	endfunction

	// Scan from the frame after the hand; caller guarantees an unpinned frame exists.
	function automatic int choose_victim();
		int start, idx;
		start = step_frame(clock_hand);
		if (policy == POLICY_FIFO) begin
			idx = start;
			for (int k = 0; k < managed; k++) begin
				if (!tbl_pinned[idx]) return idx;
				idx = step_frame(idx);
			end
			return start;
		end
		for (int pass = 0; pass < 4; pass++) begin
			idx = start;
			for (int k = 0; k < managed; k++) begin
				if (!tbl_pinned[idx]) begin
					if (!tbl_used[idx] && tbl_dirty[idx] == pass[0]) return idx;
					// the second pass strips use bits as it sweeps
					if (pass == 1) tbl_used[idx] = 1'b0;
				end
				idx = step_frame(idx);
			end
		end
		return start;
	endfunction

	// Apply one command to the shadow table and return the beat it should produce.
	function automatic frame_result_t apply_command(input logic [2:0] cmd,
			input logic [FRAME_W-1:0] frm, input logic [OWNER_BITS-1:0] own,
			input logic [PAGE_BITS-1:0] pg, input logic wr);
		frame_result_t r;
		int idx;
		bit any_loose;
		r = '0;
		r.status = ST_OK;
		if (cmd == CMD_ALLOC) begin
			idx = managed;
			for (int i = managed - 1; i >= 0; i--)
				if (tbl_free[i]) idx = i;
			if (idx == managed) begin
				any_loose = 1'b0;
				for (int i = 0; i < managed; i++)
					if (!tbl_pinned[i]) any_loose = 1'b1;
				if (!any_loose) begin
					r.status = ST_ALLPIN;
				end else begin
					idx = choose_victim();
					clock_hand = idx;
					r.evicted = 1'b1;
					r.owner = tbl_owner[idx];
					r.page = tbl_page[idx];
					r.dirty = tbl_dirty[idx];
				end
			end
			if (r.status == ST_OK) begin
				tbl_free[idx] = 1'b0;
				tbl_pinned[idx] = 1'b1;
				tbl_used[idx] = 1'b0;
				tbl_dirty[idx] = 1'b0;
				tbl_owner[idx] = own;
				tbl_page[idx] = pg;
				r.granted = FRAME_W'(idx);
			end
		end else if (cmd <= CMD_ACCESS) begin
			if (frm >= managed) begin
				r.status = ST_RANGE;
			end else begin
				case (cmd)
					CMD_FREE: begin
						tbl_free[frm] = 1'b1;
						tbl_pinned[frm] = 1'b0;
						tbl_used[frm] = 1'b0;
						tbl_dirty[frm] = 1'b0;
					end
					CMD_PIN:   tbl_pinned[frm] = 1'b1;
					CMD_UNPIN: tbl_pinned[frm] = 1'b0;
					default: begin
						tbl_used[frm] = 1'b1;
						if (wr) tbl_dirty[frm] = 1'b1;
					end
				endcase
			end
		end
		for (int i = 0; i < managed; i++)
			r.free_cnt += CNT_W'(tbl_free[i]);
		return r;
	endfunction

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		frame_result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result beat, granted_frame %0d", granted_frame);
				errors++;
			end else begin
				w = pending_q.pop_front();
				if (granted_frame !== w.granted) begin
					$error("granted_frame exp %0d got %0d", w.granted, granted_frame);
					errors++;
				end
				if (evicted !== w.evicted) begin
					$error("evicted exp %0d got %0d", w.evicted, evicted);
					errors++;
				end
				if (victim_owner !== w.owner) begin
					$error("victim_owner exp %0h got %0h", w.owner, victim_owner);
					errors++;
				end
				if (victim_page !== w.page) begin
					$error("victim_page exp %0h got %0h", w.page, victim_page);
					errors++;
				end
				if (victim_dirty !== w.dirty) begin
					$error("victim_dirty exp %0d got %0d", w.dirty, victim_dirty);
					errors++;
				end
				if (status !== w.status) begin
					$error("status exp %0d got %0d", w.status, status);
					errors++;
				end
				if (free_count !== w.free_cnt) begin
					$error("free_count exp %0d got %0d", w.free_cnt, free_count);
					errors++;
				end
			end
		end
	end

	// Result side: random stall, or a long hold-off counted here when asked.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 17);
			end
		end
	end

	// Offer one beat, hold it until taken, then predict it.
	task automatic send_beat(input logic [2:0] cmd, input logic [FRAME_W-1:0] frm,
			input logic [OWNER_BITS-1:0] own, input logic [PAGE_BITS-1:0] pg,
			input logic wr, input bit typed, input frame_result_t want);
		frame_result_t got;
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		frame <= frm;
		owner_id <= own;
		page_number <= pg;
		is_write <= wr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		got = apply_command(cmd, frm, own, pg, wr);
		pending_q.push_back(typed ? want : got);
	endtask

	// Drop valid and wait for every outstanding beat, plus settle time.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_FRAMES) set_managed(val);
		else policy = val[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic stim_row_t op(input logic [2:0] cmd, input int frm,
			input int own, input int pg, input logic wr);
		stim_row_t r;
		r = '{default: '0};
		r.cmd = cmd;
		r.frm = FRAME_W'(frm);
		r.own = OWNER_BITS'(own);
		r.pg = PAGE_BITS'(pg);
		r.wr = wr;
		return r;
	endfunction

	// Row with an expectation typed in: no victim, just grant, status and count.
	function automatic stim_row_t op_want(input logic [2:0] cmd, input int frm,
			input int own, input int pg, input logic wr, input int gr,
			input logic [1:0] st, input int fc);
		stim_row_t r;
		r = op(cmd, frm, own, pg, wr);
		r.typed = 1'b1;
		r.want = '0;
		r.want.granted = FRAME_W'(gr);
		r.want.status = st;
		r.want.free_cnt = CNT_W'(fc);
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [1:0] idx, input int val);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = CFG_W'(val);
		return r;
	endfunction

	initial begin
		logic [2:0] cmd;
		int sel, frm;
		int phase_size[10];
		bit phase_pol[10];
		frame_result_t none;
		none = '0;
		phase_size = '{4, 4, 1, 8, 0, 32, 63, 3, 6, 2};
		phase_pol = '{1, 0, 1, 1, 0, 1, 0, 1, 0, 1};

		for (int i = 0; i < NUM_FRAMES; i++) begin
			tbl_free[i] = 1'b1;
			tbl_pinned[i] = 1'b0;
			tbl_used[i] = 1'b0;
			tbl_dirty[i] = 1'b0;
			tbl_owner[i] = '0;
			tbl_page[i] = '0;
		end
		set_managed(FIU_RESET);
		clock_hand = managed - 1;
		policy = POLICY_CLOCK;

		// Full table after reset: extremes, every command, unknown codes.
		dir_rows.push_back(op_want(CMD_ALLOC, 0, 'hFF, 'hFFFFF, 1, 0, ST_OK, 31));
		dir_rows.push_back(op_want(CMD_ALLOC, 31, 0, 0, 0, 1, ST_OK, 30));
		dir_rows.push_back(op(CMD_ACCESS, 1, 0, 0, 1));
		dir_rows.push_back(op_want(CMD_PIN, 31, 0, 0, 0, 0, ST_OK, 30));
		dir_rows.push_back(op_want(CMD_UNPIN, 31, 0, 0, 0, 0, ST_OK, 30));
		dir_rows.push_back(op_want(CMD_FREE, 31, 0, 0, 0, 0, ST_OK, 30));
		dir_rows.push_back(op_want(CMD_UNKNOWN_LO, 0, 0, 0, 0, 0, ST_OK, 30));
		dir_rows.push_back(op_want(CMD_UNKNOWN_HI, 31, 'hFF, 'hFFFFF, 1, 0, ST_OK, 30));
		dir_rows.push_back(op_want(CMD_FREE, 1, 0, 0, 0, 0, ST_OK, 31));
		// Shrink to two frames under FIFO, then clock: all pinned, out of range, eviction.
		dir_rows.push_back(reg_row(CFG_FRAMES, 2));
		dir_rows.push_back(reg_row(CFG_POLICY, POLICY_FIFO));
		dir_rows.push_back(op_want(CMD_ALLOC, 0, 'h12, 'h12345, 0, 1, ST_OK, 0));
		dir_rows.push_back(op_want(CMD_ALLOC, 0, 'h34, 'h54321, 0, 0, ST_ALLPIN, 0));
		dir_rows.push_back(op_want(CMD_PIN, 2, 0, 0, 0, 0, ST_RANGE, 0));
		dir_rows.push_back(op_want(CMD_ACCESS, 31, 0, 0, 1, 0, ST_RANGE, 0));
		dir_rows.push_back(op(CMD_UNPIN, 0, 0, 0, 0));
		dir_rows.push_back(op(CMD_UNPIN, 1, 0, 0, 0));
		dir_rows.push_back(op(CMD_ACCESS, 0, 0, 0, 1));
		dir_rows.push_back(op(CMD_ALLOC, 0, 'hAA, 'hABCDE, 0));
		dir_rows.push_back(reg_row(CFG_POLICY, POLICY_CLOCK));
		dir_rows.push_back(op(CMD_UNPIN, 0, 0, 0, 0));
		dir_rows.push_back(op(CMD_ACCESS, 1, 0, 0, 0));
		dir_rows.push_back(op(CMD_ALLOC, 0, 'h55, 'h0F0F0, 1));
		dir_rows.push_back(op_want(CMD_FREE, 1, 0, 0, 0, 0, ST_OK, 1));
		dir_rows.push_back(op_want(CMD_FREE, 0, 0, 0, 0, 0, ST_OK, 2));
		// Register value zero clamps to a single frame.
		dir_rows.push_back(reg_row(CFG_FRAMES, 0));
		dir_rows.push_back(op_want(CMD_ALLOC, 0, 1, 1, 0, 0, ST_OK, 0));
		dir_rows.push_back(op_want(CMD_FREE, 1, 0, 0, 0, 0, ST_RANGE, 0));

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
			else
				send_beat(dir_rows[i].cmd, dir_rows[i].frm, dir_rows[i].own,
					dir_rows[i].pg, dir_rows[i].wr, dir_rows[i].typed, dir_rows[i].want);
		end

		// Random phases, each under its own size and policy.
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(CFG_FRAMES, CFG_W'(phase_size[ph]));
			write_reg(CFG_POLICY, CFG_W'(phase_pol[ph]));
			quiet = (ph == 5);
			for (int n = 0; n < 50; n++) begin
				if (ph == 2 && n == 10) hold_req = 1'b1;
				if (ph == 3 && n == 25) drain();
				sel = $urandom_range(99);
				if (sel < 40) cmd = CMD_ALLOC;
				else if (sel < 50) cmd = CMD_FREE;
				else if (sel < 58) cmd = CMD_PIN;
				else if (sel < 75) cmd = CMD_UNPIN;
				else if (sel < 95) cmd = CMD_ACCESS;
				else cmd = 3'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
				frm = ($urandom_range(99) < 85) ? $urandom_range(managed - 1)
					: $urandom_range(NUM_FRAMES - 1);
				send_beat(cmd, FRAME_W'(frm), OWNER_BITS'($urandom),
					PAGE_BITS'($urandom), 1'($urandom), 1'b0, none);
			end
		end
		quiet = 1'b0;

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_q.size() != 0) begin
			$error("%0d expected beats never arrived", pending_q.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[page_frame_allocator_clock.f]
hdl/pfa_pkg.sv
hdl/pfa_ram.sv
hdl/page_frame_allocator_clock.sv
tb/sv/testbench.sv
